FILE: src/crlf_line_command_parser_assert.svh
// assertion macros for the crlf line command parser rtl
`ifndef CRLF_LINE_COMMAND_PARSER_ASSERT_SVH
`define CRLF_LINE_COMMAND_PARSER_ASSERT_SVH

// checked on every clock edge once reset is released
`define CLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("clp assertion failed");

// checked on every clock edge, reset included
`define CLP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("clp assertion failed");

`endif

FILE: src/clpr_pkg.sv
// types and constants shared by the crlf line command parser
`timescale 1ns / 1ps

package clpr_pkg;

  localparam int unsigned HeadDepth = 8;
  localparam int unsigned LenWidth  = 4;
  localparam int unsigned IdxWidth  = 3;

  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;

  localparam logic [LenWidth-1:0] LEN_MAX = 4'hF;

  // command texts, first character at index 0
  localparam logic [5:0][7:0] TEXT_STOP = {BYTE_LF, BYTE_CR, "P", "O", "T", "S"};
  localparam logic [2:0][7:0] TEXT_RUN  = {"N", "U", "R"};
  localparam logic [2:0][7:0] TEXT_A    = {BYTE_LF, BYTE_CR, "A"};
  localparam logic [2:0][7:0] TEXT_B    = {BYTE_LF, BYTE_CR, "B"};

  typedef enum logic [2:0] {
    KIND_STOP  = 3'd0,
    KIND_RUN   = 3'd1,
    KIND_A     = 3'd2,
    KIND_B     = 3'd3,
    KIND_OTHER = 3'd4
  } line_kind_e;

  // first bytes of a finished line, unwritten bytes are zero
  typedef struct packed {
    logic [HeadDepth-1:0][7:0] head;
  } line_t;

endpackage

FILE: src/crlf_line_command_parser.sv
// top level of the crlf line command parser
`timescale 1ns / 1ps
`include "crlf_line_command_parser_assert.svh"

// a line result passes the gather line register, then the classify result register, after its lf item is taken
// throughput: one byte item per cycle while s_axis_tready is high, set by the gather and classify registers
// a result waiting at the output does not stop new bytes until a second line ends
// reset (async, active low) clears the line buffer, length, last byte, speed and stop flag
module crlf_line_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // line results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] speed_tenths, [16] stop_flag, rest zero
  output logic [2:0]  m_axis_tuser    // [2:0] line_kind
);
  import clpr_pkg::*;

  logic       line_vld, line_rdy;
  line_t      line;
  logic [15:0] speed;
  logic       stop;
  logic       lf_take;

  // gathers bytes into the line buffer, hands over a line at each cr lf
  clpr_gather u_gather (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (s_axis_tvalid),
    .byte_rdy_o (s_axis_tready),
    .byte_i     (s_axis_tdata),
    .line_vld_o (line_vld),
    .line_rdy_i (line_rdy),
    .line_o     (line)
  );

  // decodes the line, updates speed and stop flag, holds the result
  clpr_classify u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .line_vld_i (line_vld),
    .line_rdy_o (line_rdy),
    .line_i     (line),
    .res_vld_o  (m_axis_tvalid),
    .res_rdy_i  (m_axis_tready),
    .kind_o     (m_axis_tuser),
    .speed_o    (speed),
    .stop_o     (stop)
  );

  assign m_axis_tdata = {7'b0, stop, speed};

  // an lf item taken at this edge
  assign lf_take = s_axis_tvalid && s_axis_tready && (s_axis_tdata == BYTE_LF);

  // a stop result always carries zero speed and the flag set
  `CLP_ASSERT(a_stop_result, (m_axis_tvalid && m_axis_tuser == KIND_STOP) |-> (stop && speed == '0))
  // a run result always clears the flag
  `CLP_ASSERT(a_run_result, (m_axis_tvalid && m_axis_tuser == KIND_RUN) |-> !stop)
  // a finished line only appears right after an lf item was taken
  `CLP_ASSERT(a_line_from_lf, $rose(line_vld) |-> $past(lf_take))
  // a new result only appears after a line was pending
  `CLP_ASSERT(a_res_from_line, $rose(m_axis_tvalid) |-> $past(line_vld))

endmodule

FILE: src/clpr_gather.sv
// line gather stage: collects bytes and hands over each finished line
`timescale 1ns / 1ps

module clpr_gather (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_vld_i,
  output logic           byte_rdy_o,
  input  logic [7:0]     byte_i,
  output logic           line_vld_o,
  input  logic           line_rdy_i,
  output clpr_pkg::line_t line_o
);
  import clpr_pkg::*;

  logic [HeadDepth-1:0][7:0] head_q, head_d, head_new;
  logic [LenWidth-1:0]       len_q, len_d;
  logic [7:0]                prev_q, prev_d;
  logic                      line_vld_q, line_vld_d;
  line_t                     line_q, line_d;
  logic                      take, ends;

  assign byte_rdy_o = !line_vld_q || line_rdy_i;
  assign take       = byte_vld_i && byte_rdy_o;
  assign ends       = (len_q != '0) && (prev_q == BYTE_CR) && (byte_i == BYTE_LF);

  always_comb begin
    head_new = head_q;
    if (!len_q[LenWidth-1]) begin
      head_new[len_q[IdxWidth-1:0]] = byte_i;
    end
    head_d     = head_q;
    len_d      = len_q;
    prev_d     = prev_q;
    line_d     = line_q;
    line_vld_d = line_vld_q && !line_rdy_i;
    if (take) begin
      prev_d = byte_i;
      if (ends) begin
        line_d.head = head_new;
        line_vld_d  = 1'b1;
        head_d      = '0;
        len_d       = '0;
      end else begin
        head_d = head_new;
        if (len_q != LEN_MAX) begin
          len_d = len_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      len_q      <= '0;
      prev_q     <= '0;
      line_vld_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      len_q      <= len_d;
      prev_q     <= prev_d;
      line_vld_q <= line_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
  end

  assign line_vld_o = line_vld_q;
  assign line_o     = line_q;

endmodule

FILE: src/clpr_classify.sv
// classify stage: decodes a finished line and holds speed and stop state
`timescale 1ns / 1ps

module clpr_classify (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            line_vld_i,
  output logic            line_rdy_o,
  input  clpr_pkg::line_t line_i,
  output logic            res_vld_o,
  input  logic            res_rdy_i,
  output logic [2:0]      kind_o,
  output logic [15:0]     speed_o,
  output logic            stop_o
);
  import clpr_pkg::*;

  logic signed [15:0] speed_q, speed_d;
  logic               stop_q, stop_d;
  logic               res_vld_q, res_vld_d;
  line_kind_e         kind_q, kind_d;
  logic               adv;
  logic signed [15:0] d4, d5, d7, mag;

  assign line_rdy_o = !res_vld_q || res_rdy_i;
  assign adv        = line_vld_i && line_rdy_o;

  // digits are byte minus ascii zero, unchecked
  assign d4  = $signed({8'h00, line_i.head[4]}) - $signed({8'h00, BYTE_ZERO});
  assign d5  = $signed({8'h00, line_i.head[5]}) - $signed({8'h00, BYTE_ZERO});
  assign d7  = $signed({8'h00, line_i.head[7]}) - $signed({8'h00, BYTE_ZERO});
  assign mag = d4 * 16'sd100 + d5 * 16'sd10 + d7;

  always_comb begin
    speed_d   = speed_q;
    stop_d    = stop_q;
    kind_d    = kind_q;
    res_vld_d = res_vld_q && !res_rdy_i;
    if (adv) begin
      res_vld_d = 1'b1;
      if (line_i.head[5:0] == TEXT_STOP) begin
        kind_d  = KIND_STOP;
        speed_d = '0;
        stop_d  = 1'b1;
      end else if (line_i.head[2:0] == TEXT_RUN) begin
        kind_d  = KIND_RUN;
        stop_d  = 1'b0;
        speed_d = (line_i.head[3] == BYTE_MINUS) ? -mag : mag;
      end else if (line_i.head[2:0] == TEXT_A) begin
        kind_d = KIND_A;
      end else if (line_i.head[2:0] == TEXT_B) begin
        kind_d = KIND_B;
      end else begin
        kind_d = KIND_OTHER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= '0;
      stop_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      speed_q   <= speed_d;
      stop_q    <= stop_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  // speed and stop state only move when the held result has been taken
  assign res_vld_o = res_vld_q;
  assign kind_o    = kind_q;
  assign speed_o   = speed_q;
  assign stop_o    = stop_q;

endmodule

FILE: tb/tb_crlf_line_command_parser.sv
// self-checking testbench for the crlf line command parser
`timescale 1ns / 1ps

module tb_crlf_line_command_parser;
  import clpr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 10;

  // receiver pacing patterns
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE
  } rx_pace_e;

  // one line result as the block should report it
  typedef struct packed {
    line_kind_e  kind;
    logic [15:0] speed;
    logic        stop;
  } line_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [15:0] speed_tenths, [16] stop_flag, rest zero
  logic [2:0]  m_axis_tuser;           // [2:0] line_kind

  crlf_line_command_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // line parser shadow state, updated once per accepted item
  logic [7:0]         line_head [HeadDepth];
  logic [LenWidth-1:0] line_len;
  logic [7:0]         last_rx;
  logic [15:0]        cmd_speed;
  logic               cmd_stop;

  line_result_t expected_lines [$];

  // sender and receiver pacing
  rx_pace_e rx_pace = RX_ALWAYS;
  bit       sender_steady = 1'b1;
  int       burst_left = 0;
  int       hold_left = 0;
  int       pace_cnt = 0;

  // bookkeeping
  int cycle_count = 0;
  int fail_count = 0;
  int lines_checked = 0;
  int bytes_sent = 0;
  int input_stalls = 0;
  int kind_seen [5];

  // compare the first n bytes of the current line with a command text
  function automatic bit head_has(input logic [5:0][7:0] text, input int n);
    for (int i = 0; i < n; i++) begin
      if (line_head[i] !== text[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the shadow parser by one byte, hand back a result at a line end
  function automatic void parse_byte(input logic [7:0] rx, output bit done,
                                     output line_result_t res);
    bit ends;
    int mag;
    int sp;
    // the first byte of a line never closes it
    ends = (line_len != 0) && (last_rx == BYTE_CR) && (rx == BYTE_LF);
    // bytes past the head are dropped, length saturates
    if (line_len < HeadDepth) line_head[line_len[IdxWidth-1:0]] = rx;
    if (line_len < LEN_MAX) line_len = line_len + 1'b1;
    last_rx = rx;
    done = ends;
    res = '0;
    if (ends) begin
      if (head_has(TEXT_STOP, 6)) begin
        cmd_speed = '0;
        cmd_stop = 1'b1;
        res.kind = KIND_STOP;
      end else if (head_has(48'(TEXT_RUN), 3)) begin
        // digits are taken raw, missing bytes read as zero
        mag = (int'(line_head[4]) - int'(BYTE_ZERO)) * 100
            + (int'(line_head[5]) - int'(BYTE_ZERO)) * 10
            + (int'(line_head[7]) - int'(BYTE_ZERO));
        sp = (line_head[3] == BYTE_MINUS) ? -mag : mag;
        cmd_speed = 16'(sp);
        cmd_stop = 1'b0;
        res.kind = KIND_RUN;
      end else if (head_has(48'(TEXT_A), 3)) begin
        res.kind = KIND_A;
      end else if (head_has(48'(TEXT_B), 3)) begin
        res.kind = KIND_B;
      end else begin
        res.kind = KIND_OTHER;
      end
      res.speed = cmd_speed;
      res.stop = cmd_stop;
      for (int i = 0; i < HeadDepth; i++) line_head[i] = 8'h00;
      line_len = '0;
    end
  endfunction

  // offer one byte, sender idles between bursts unless steady
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    bit done;
    line_result_t res;
    if (!sender_steady && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(rx, done, res);
    if (done) expected_lines.push_back(res);
    bytes_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
  endtask

  task automatic send_crlf();
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
  endtask

  // run command body: RUN, sign, two digits, point, one digit
  task automatic send_run(input logic [7:0] sign, input logic [7:0] d4,
                          input logic [7:0] d5, input logic [7:0] dot,
                          input logic [7:0] d7);
    send_text("RUN");
    send_byte(sign);
    send_byte(d4);
    send_byte(d5);
    send_byte(dot);
    send_byte(d7);
  endtask

  // mostly a decimal digit, sometimes any byte
  function automatic logic [7:0] pick_digit();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return BYTE_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // one random line, mostly well formed, some broken, some noise
  task automatic send_random_line();
    int choice;
    int n;
    int pos;
    int sel;
    string txt;
    logic [7:0] b;
    logic [7:0] sign;
    choice = $urandom_range(0, 99);
    if (choice < 35) begin
      sel = $urandom_range(0, 9);
      sign = (sel < 4) ? BYTE_MINUS : (sel < 8) ? "+" : 8'($urandom);
      send_run(sign, pick_digit(), pick_digit(),
               ($urandom_range(0, 9) == 0) ? 8'($urandom) : ".", pick_digit());
      // trailing bytes after the speed are ignored
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_byte(8'($urandom));
      end
      send_crlf();
    end else if (choice < 45) begin
      send_text("STOP");
      send_crlf();
    end else if (choice < 53) begin
      send_text("A");
      send_crlf();
    end else if (choice < 61) begin
      send_text("B");
      send_crlf();
    end else if (choice < 71) begin
      // broken command: cut short, one byte altered, or one byte added
      sel = $urandom_range(0, 3);
      if (sel == 0) txt = "STOP";
      else if (sel == 1) txt = "RUN-1";
      else if (sel == 2) txt = "A";
      else txt = "B";
      sel = $urandom_range(0, 2);
      n = (sel == 0) ? $urandom_range(0, txt.len() - 1) : txt.len();
      pos = $urandom_range(0, txt.len() - 1);
      for (int i = 0; i < n; i++) begin
        b = txt[i];
        if (sel == 1 && i == pos) b = 8'($urandom);
        send_byte(b);
      end
      if (sel == 2) send_byte(8'($urandom));
      send_crlf();
    end else if (choice < 86) begin
      // random body, long ones run past the head and the length limit
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) send_byte(8'($urandom));
      send_crlf();
    end else begin
      // stray cr and lf bytes with no forced line end
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 2);
        send_byte((sel == 0) ? BYTE_CR : (sel == 1) ? BYTE_LF : 8'($urandom));
      end
    end
  endtask

  // each command, sign and digit extreme, and the odd line shapes
  task automatic test_directed_lines();
    rx_pace = RX_ALWAYS;
    sender_steady = 1'b1;
    // lf as the very first byte does not end a line
    send_byte(BYTE_LF);
    send_crlf();
    send_text("STOP");
    send_crlf();
    send_run("+", "1", "2", ".", "3");
    send_crlf();
    send_run(BYTE_MINUS, "9", "9", ".", "9");
    send_crlf();
    // bare run reads cr as the sign and lf and zero bytes as digits
    send_text("RUN");
    send_crlf();
    send_text("A");
    send_crlf();
    send_text("B");
    send_crlf();
    send_text("AB");
    send_crlf();
    send_text("STOPX");
    send_crlf();
    // empty line
    send_crlf();
    // digit extremes in both signs
    send_run(BYTE_MINUS, 8'hFF, 8'hFF, ".", 8'hFF);
    send_crlf();
    send_run("+", 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_crlf();
    send_run(BYTE_MINUS, 8'h00, 8'h00, 8'h00, 8'h00);
    send_crlf();
    send_run("+", "0", "0", ".", "0");
    send_crlf();
    // any sign byte other than minus is positive
    send_run("x", "4", "5", ".", "6");
    send_crlf();
    // type a reports the speed and flag as they stand
    send_text("STOP");
    send_crlf();
    send_text("A");
    send_crlf();
    // over-long lines keep the head and saturate the length
    send_text("RUN-45.6789012345678901");
    send_crlf();
    for (int i = 0; i < 30; i++) send_byte(8'($urandom_range(32, 126)));
    send_crlf();
    // lone cr bytes inside a line
    send_byte(BYTE_CR);
    send_crlf();
    send_text("A");
    send_byte(BYTE_CR);
    send_text("x");
    send_crlf();
    send_text("B");
    send_crlf();
  endtask

  task automatic test_random_traffic(input int n_bytes, input rx_pace_e pace,
                                     input bit steady);
    int stop_at;
    rx_pace = pace;
    sender_steady = steady;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_line();
  endtask

  // receiver holds off while short lines keep coming, so the input stalls
  task automatic test_output_hold();
    int sel;
    rx_pace = RX_ALWAYS;
    sender_steady = 1'b1;
    hold_left <= 400;
    for (int i = 0; i < 60; i++) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) send_text("A");
      else if (sel == 1) send_text("B");
      else send_text("STOP");
      send_crlf();
    end
  endtask

  initial begin
    for (int i = 0; i < HeadDepth; i++) line_head[i] = 8'h00;
    line_len = '0;
    last_rx = 8'h00;
    cmd_speed = '0;
    cmd_stop = 1'b0;
    for (int i = 0; i < 5; i++) kind_seen[i] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lines();
    test_random_traffic(350, RX_ALWAYS, 1'b1);
    test_random_traffic(350, RX_RANDOM, 1'b0);
    test_output_hold();
    test_random_traffic(400, RX_SPARSE, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_lines.size() != 0) fail_count++;

    $display("sent %0d bytes, checked %0d lines: stop %0d, run %0d, a %0d, b %0d, other %0d",
             bytes_sent, lines_checked, kind_seen[KIND_STOP], kind_seen[KIND_RUN],
             kind_seen[KIND_A], kind_seen[KIND_B], kind_seen[KIND_OTHER]);
    $display("input held back on %0d cycles, %0d bad results", input_stalls, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: long hold-off first, otherwise the current pacing pattern
  always @(posedge clk_i) begin
    pace_cnt <= pace_cnt + 1;
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      case (rx_pace)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
        default:   m_axis_tready <= (pace_cnt % 5 == 0) || ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // each accepted result against the oldest expected line
  always @(posedge clk_i) begin : check_lines
    line_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_lines.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
          $display("unexpected line result: kind %0d speed %0d stop %0d",
                   m_axis_tuser, $signed(m_axis_tdata[15:0]), m_axis_tdata[16]);
        end
      end else begin
        want = expected_lines.pop_front();
        lines_checked++;
        kind_seen[want.kind]++;
        if (m_axis_tuser !== want.kind || m_axis_tdata[15:0] !== want.speed ||
            m_axis_tdata[16] !== want.stop || m_axis_tdata[23:17] !== 7'd0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("line %0d: expected kind %0d speed %0d stop %0d",
                     lines_checked, want.kind, $signed(want.speed), want.stop);
            $display("  got kind %0d speed %0d stop %0d pad %h",
                     m_axis_tuser, $signed(m_axis_tdata[15:0]), m_axis_tdata[16],
                     m_axis_tdata[23:17]);
          end
        end
      end
    end
  end

  // input backpressure count and run watchdog
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stalls <= input_stalls + 1;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

FILE: crlf_line_command_parser.f
+incdir+src
src/clpr_pkg.sv
src/clpr_gather.sv
src/clpr_classify.sv
src/crlf_line_command_parser.sv
tb/tb_crlf_line_command_parser.sv
